[src/grc_pkg.sv]
// ----------------------------------------------------------------------------
// grc_pkg
// shared widths, register indexes, reset values and wall colours
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package grc_pkg;

	localparam int MAP_SIDE_DEF    = 32;
	localparam int SCREEN_COLS_DEF = 800;
	localparam int SCREEN_ROWS_DEF = 640;
	localparam int FRAC_BITS_DEF   = 16;

	localparam int POS_W    = 21;
	localparam int DIR_W    = 18;
	localparam int CELL_W   = 5;
	localparam int CODE_W   = 3;
	localparam int COL_W    = 10;
	localparam int ROW_W    = 10;
	localparam int RGB_W    = 24;
	localparam int IDX_W    = 3;
	localparam int CFG_W    = 21;
	localparam int S_DATA_W = 24;
	localparam int M_DATA_W = 64;
	localparam int M_PAD_W  = M_DATA_W - (COL_W + 2 * ROW_W + CODE_W + 1 + RGB_W);

	localparam logic [IDX_W-1:0] REG_POS_X   = 3'd0;
	localparam logic [IDX_W-1:0] REG_POS_Y   = 3'd1;
	localparam logic [IDX_W-1:0] REG_DIR_X   = 3'd2;
	localparam logic [IDX_W-1:0] REG_DIR_Y   = 3'd3;
	localparam logic [IDX_W-1:0] REG_PLANE_X = 3'd4;
	localparam logic [IDX_W-1:0] REG_PLANE_Y = 3'd5;

	localparam logic [POS_W-1:0] POS_X_RST   = 21'd1441792;
	localparam logic [POS_W-1:0] POS_Y_RST   = 21'd786432;
	localparam logic [DIR_W-1:0] DIR_X_RST   = 18'h30000;
	localparam logic [DIR_W-1:0] DIR_Y_RST   = 18'd0;
	localparam logic [DIR_W-1:0] PLANE_X_RST = 18'd0;
	localparam logic [DIR_W-1:0] PLANE_Y_RST = 18'd43254;

	localparam logic [CODE_W-1:0] CODE_RED   = 3'd1;
	localparam logic [CODE_W-1:0] CODE_GREEN = 3'd2;
	localparam logic [CODE_W-1:0] CODE_BLUE  = 3'd3;
	localparam logic [CODE_W-1:0] CODE_WHITE = 3'd4;

	localparam logic [RGB_W-1:0] RGB_RED    = 24'hFF0000;
	localparam logic [RGB_W-1:0] RGB_GREEN  = 24'h00FF00;
	localparam logic [RGB_W-1:0] RGB_BLUE   = 24'h0000FF;
	localparam logic [RGB_W-1:0] RGB_WHITE  = 24'hFFFFFF;
	localparam logic [RGB_W-1:0] RGB_YELLOW = 24'hFFFF00;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

	function automatic logic [RGB_W-1:0] wall_colour(input logic [CODE_W-1:0] code,
		input logic side);
		logic [RGB_W-1:0] c;
		case (code)
			CODE_RED:   c = RGB_RED;
			CODE_GREEN: c = RGB_GREEN;
			CODE_BLUE:  c = RGB_BLUE;
			CODE_WHITE: c = RGB_WHITE;
			default:    c = RGB_YELLOW;
		endcase
		return side ? (c >> 1) : c;
	endfunction

endpackage

[src/grc_ram.sv]
// ----------------------------------------------------------------------------
// grc_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module grc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end

endmodule

[src/grc_div.sv]
// ----------------------------------------------------------------------------
// grc_div
// restoring unsigned divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module grc_div #(
	parameter int NUM_W = 8,
	parameter int DEN_W = 8
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [NUM_W-1:0]    num,
	input  logic [DEN_W-1:0]    den,
	output grc_pkg::div_stat_t  stat,
	output logic [NUM_W-1:0]    quo
);

	import grc_pkg::*;

	localparam int CNT_W = $clog2(NUM_W + 1);

	logic [NUM_W-1:0] nq_q;
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [DEN_W:0]   trial;
	logic [DEN_W:0]   diff;
	logic             ge;

	always_comb begin
		trial = {rem_q, nq_q[NUM_W-1]};
		diff  = trial - {1'b0, den_q};
		ge    = trial >= {1'b0, den_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nq_q   <= '0;
			rem_q  <= '0;
			den_q  <= '0;
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				nq_q   <= num;
				rem_q  <= '0;
				den_q  <= den;
				cnt_q  <= CNT_W'(NUM_W);
				busy_q <= 1'b1;
			end else if (busy_q) begin
				nq_q  <= {nq_q[NUM_W-2:0], ge};
				rem_q <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign stat = '{busy: busy_q, done: done_q};
	assign quo  = nq_q;

endmodule

[src/grid_raycast_wall_column.sv]
// ----------------------------------------------------------------------------
// grid_raycast_wall_column
// grid dda raycaster giving one clamped wall stripe per cast column
// ----------------------------------------------------------------------------
// Holds a MAP_SIDE x MAP_SIDE map of 3-bit wall codes in a ram. An item with
// tuser 0 writes one cell. An item with tuser 1 casts the ray of one screen
// column and returns one result item. The camera offset comes from a
// reciprocal multiplication in the ST_CAM and ST_CAMW states. A single
// bit-serial divider serves both step lengths and the stripe height, and is
// skipped when the divisor is zero. Each step of the grid walk passes the
// ST_STEP and ST_ADDR states and, inside the map, ST_HIT, because every step
// reads the map ram, for at most 2*MAP_SIDE+4 cells. One item is worked at
// a time; the result waits in an output register while the next item is
// taken. After reset all MAP_SIDE*MAP_SIDE cells of the map are cleared, one
// cell per cycle, with no item accepted in that time; configuration writes
// are taken at any time.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module grid_raycast_wall_column #(
	parameter int MAP_SIDE    = grc_pkg::MAP_SIDE_DEF,
	parameter int SCREEN_COLS = grc_pkg::SCREEN_COLS_DEF,
	parameter int SCREEN_ROWS = grc_pkg::SCREEN_ROWS_DEF,
	parameter int FRAC_BITS   = grc_pkg::FRAC_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// cell_x, cell_y, cell_code, column
	input  logic [grc_pkg::S_DATA_W-1:0]  s_tdata,
	// mode
	input  logic                          s_tuser,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// out_column, draw_start, draw_end, hit_code, hit_side, colour
	output logic [grc_pkg::M_DATA_W-1:0]  m_tdata,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [grc_pkg::IDX_W-1:0]     cfg_index,
	input  logic [grc_pkg::CFG_W-1:0]     cfg_data
);

	import grc_pkg::*;

	localparam int F        = FRAC_BITS;
	localparam int NUM_W    = 2 * F + 14;
	localparam int DEN_W    = (2 * F + 2 > 34) ? 2 * F + 2 : 34;
	localparam int DIST_W   = F + 16;
	localparam int CAM_W    = F + 15;
	localparam int CAM_E    = 25;
	localparam int CMUL_W   = 16 + F + CAM_E;
	localparam int PROD_W   = DIR_W + CAM_W;
	localparam int RAY_W    = PROD_W - F + 1;
	localparam int FX_W     = F + 1;
	localparam int SP_W     = FX_W + DIST_W;
	localparam int MPOS_W   = POS_W + 2;
	localparam int CW       = $clog2(MAP_SIDE);
	localparam int DEPTH    = MAP_SIDE * MAP_SIDE;
	localparam int AW       = $clog2(DEPTH);
	localparam int ITER_MAX = 2 * MAP_SIDE + 4;
	localparam int IT_W     = $clog2(ITER_MAX + 1);
	localparam int LINE_MAX = 2 * SCREEN_ROWS;
	localparam int LINE_W   = $clog2(LINE_MAX + 1);
	localparam int RC_W     = LINE_W + 1;
	localparam int HALF_ROWS = SCREEN_ROWS / 2;

	localparam logic [DIST_W-1:0]        DIST_SAT = '1;
	localparam logic signed [MPOS_W-1:0] SIDE_S   = MPOS_W'(MAP_SIDE);
	// rounded-up reciprocal of the screen width, exact for every column
	localparam logic [CMUL_W-1:0]        CAM_RECIP = CMUL_W'(((64'd1 << (F + CAM_E)) +
		64'(SCREEN_COLS) - 64'd1) / 64'(SCREEN_COLS));

	typedef enum logic [4:0] {
		ST_CLR, ST_IDLE, ST_CAM, ST_CAMW, ST_RAY, ST_DIR, ST_DX, ST_DXW,
		ST_DY, ST_DYW, ST_SIDE, ST_STEP, ST_ADDR, ST_HIT, ST_LINE, ST_LINEW, ST_FIN
	} state_t;

	state_t st_q;

	logic [POS_W-1:0]         pos_x_q, pos_y_q;
	logic signed [DIR_W-1:0]  dir_x_q, dir_y_q, plane_x_q, plane_y_q;

	logic [AW-1:0]            clr_q;
	logic [COL_W-1:0]         col_q;
	logic [CMUL_W-1:0]        cam_mul_q;
	logic signed [CAM_W-1:0]  cam_q;
	logic signed [PROD_W-1:0] prod_x_q, prod_y_q;
	logic                     neg_x_q, neg_y_q;
	logic [RAY_W-1:0]         mag_x_q, mag_y_q;
	logic [DIST_W-1:0]        dx_q, dy_q, side_x_q, side_y_q;
	logic signed [MPOS_W-1:0] mx_q, my_q;
	logic [IT_W-1:0]          it_q;
	logic                     side_q;
	logic [CODE_W-1:0]        code_q;
	logic [LINE_W-1:0]        line_q;

	logic                     acc;
	logic [CELL_W-1:0]        in_cx, in_cy;
	logic [CODE_W-1:0]        in_code;
	logic [COL_W-1:0]         in_col;
	logic                     wr_en;
	logic [AW-1:0]            wr_addr, rd_addr;
	logic [CODE_W-1:0]        wr_data, rd_data;

	logic                     div_start;
	logic [NUM_W-1:0]         div_num, div_quo;
	logic [DEN_W-1:0]         div_den;
	div_stat_t                div_stat;

	logic signed [15:0]       cd;
	logic [15:0]              cam_mag;
	logic signed [RAY_W-1:0]  ray_x, ray_y;
	logic [FX_W-1:0]          fx_raw_x, fx_raw_y, fx_x, fx_y;
	logic [SP_W-1:0]          sp_x, sp_y;
	logic [DIST_W:0]          sum_x, sum_y;
	logic [DIST_W-1:0]        perp;
	logic                     off_map;
	logic [DIST_W-1:0]        q_dist;
	logic [RC_W-1:0]          half, dstart, dend;
	logic [RGB_W-1:0]         colour;

	assign s_tready  = (st_q == ST_IDLE);
	assign cfg_ready = 1'b1;
	assign acc       = s_tvalid && s_tready;
	assign in_cx     = s_tdata[4:0];
	assign in_cy     = s_tdata[9:5];
	assign in_code   = s_tdata[12:10];
	assign in_col    = s_tdata[22:13];

	always_comb begin
		if (st_q == ST_CLR) begin
			wr_en   = 1'b1;
			wr_addr = clr_q;
			wr_data = '0;
		end else begin
			wr_en   = acc && !s_tuser && (32'(in_cx) < MAP_SIDE) && (32'(in_cy) < MAP_SIDE);
			wr_addr = AW'(AW'(in_cx) * AW'(MAP_SIDE)) + AW'(in_cy);
			wr_data = in_code;
		end
		rd_addr = AW'(AW'(mx_q[CW-1:0]) * AW'(MAP_SIDE)) + AW'(my_q[CW-1:0]);
	end

	grc_ram #(
		.WIDTH (CODE_W),
		.DEPTH (DEPTH)
	) u_map (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	grc_div #(
		.NUM_W (NUM_W),
		.DEN_W (DEN_W)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.stat   (div_stat),
		.quo    (div_quo)
	);

	always_comb begin
		cd      = $signed(16'({col_q, 1'b0})) - $signed(16'(SCREEN_COLS));
		cam_mag = cd[15] ? 16'(-cd) : 16'(cd);
		ray_x   = RAY_W'(dir_x_q) + RAY_W'(prod_x_q >>> F);
		ray_y   = RAY_W'(dir_y_q) + RAY_W'(prod_y_q >>> F);
		fx_raw_x = FX_W'(64'(pos_x_q) & ((64'd1 << F) - 64'd1));
		fx_raw_y = FX_W'(64'(pos_y_q) & ((64'd1 << F) - 64'd1));
		fx_x    = neg_x_q ? fx_raw_x : (FX_W'(1) << F) - fx_raw_x;
		fx_y    = neg_y_q ? fx_raw_y : (FX_W'(1) << F) - fx_raw_y;
		sp_x    = SP_W'(fx_x) * SP_W'(dx_q);
		sp_y    = SP_W'(fx_y) * SP_W'(dy_q);
		sum_x   = {1'b0, side_x_q} + {1'b0, dx_q};
		sum_y   = {1'b0, side_y_q} + {1'b0, dy_q};
		perp    = side_q ? side_y_q - dy_q : side_x_q - dx_q;
		off_map = mx_q[MPOS_W-1] || (mx_q >= SIDE_S) || my_q[MPOS_W-1] || (my_q >= SIDE_S);
		q_dist  = (div_quo > NUM_W'(DIST_SAT)) ? DIST_SAT : DIST_W'(div_quo);
		half    = RC_W'(line_q >> 1);
		dstart  = (half >= RC_W'(HALF_ROWS)) ? '0 : RC_W'(HALF_ROWS) - half;
		dend    = (half + RC_W'(HALF_ROWS) >= RC_W'(SCREEN_ROWS)) ?
			RC_W'(SCREEN_ROWS - 1) : half + RC_W'(HALF_ROWS);
		colour  = wall_colour(code_q, side_q);
	end

	always_comb begin
		div_start = 1'b0;
		div_num   = '0;
		div_den   = '0;
		unique case (st_q)
			ST_DX: begin
				div_start = (mag_x_q != '0);
				div_num   = NUM_W'(1) << (2 * F);
				div_den   = DEN_W'(mag_x_q);
			end
			ST_DY: begin
				div_start = (mag_y_q != '0);
				div_num   = NUM_W'(1) << (2 * F);
				div_den   = DEN_W'(mag_y_q);
			end
			ST_LINE: begin
				div_start = (perp != '0);
				div_num   = NUM_W'(SCREEN_ROWS) << F;
				div_den   = DEN_W'(perp);
			end
			default: begin
				div_start = 1'b0;
			end
		endcase
	end

	// camera registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_x_q   <= POS_X_RST;
			pos_y_q   <= POS_Y_RST;
			dir_x_q   <= DIR_X_RST;
			dir_y_q   <= DIR_Y_RST;
			plane_x_q <= PLANE_X_RST;
			plane_y_q <= PLANE_Y_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_POS_X:   pos_x_q   <= cfg_data[POS_W-1:0];
				REG_POS_Y:   pos_y_q   <= cfg_data[POS_W-1:0];
				REG_DIR_X:   dir_x_q   <= cfg_data[DIR_W-1:0];
				REG_DIR_Y:   dir_y_q   <= cfg_data[DIR_W-1:0];
				REG_PLANE_X: plane_x_q <= cfg_data[DIR_W-1:0];
				REG_PLANE_Y: plane_y_q <= cfg_data[DIR_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q      <= ST_CLR;
			clr_q     <= '0;
			col_q     <= '0;
			cam_mul_q <= '0;
			cam_q     <= '0;
			prod_x_q  <= '0;
			prod_y_q  <= '0;
			neg_x_q   <= 1'b0;
			neg_y_q   <= 1'b0;
			mag_x_q   <= '0;
			mag_y_q   <= '0;
			dx_q      <= '0;
			dy_q      <= '0;
			side_x_q  <= '0;
			side_y_q  <= '0;
			mx_q      <= '0;
			my_q      <= '0;
			it_q      <= '0;
			side_q    <= 1'b0;
			code_q    <= '0;
			line_q    <= '0;
			m_tvalid  <= 1'b0;
			m_tdata   <= '0;
		end else begin
			if (m_tvalid && m_tready && st_q != ST_FIN) begin
				m_tvalid <= 1'b0;
			end
			unique case (st_q)
				ST_CLR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == AW'(DEPTH - 1)) begin
						st_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (acc && s_tuser) begin
						col_q <= in_col;
						st_q  <= ST_CAM;
					end
				end
				ST_CAM: begin
					cam_mul_q <= CMUL_W'(cam_mag) * CAM_RECIP;
					st_q      <= ST_CAMW;
				end
				ST_CAMW: begin
					cam_q <= cd[15] ? -CAM_W'(cam_mul_q >> CAM_E) : CAM_W'(cam_mul_q >> CAM_E);
					st_q  <= ST_RAY;
				end
				ST_RAY: begin
					prod_x_q <= PROD_W'(plane_x_q) * PROD_W'(cam_q);
					prod_y_q <= PROD_W'(plane_y_q) * PROD_W'(cam_q);
					st_q     <= ST_DIR;
				end
				ST_DIR: begin
					neg_x_q <= ray_x[RAY_W-1];
					neg_y_q <= ray_y[RAY_W-1];
					mag_x_q <= ray_x[RAY_W-1] ? RAY_W'(-ray_x) : RAY_W'(ray_x);
					mag_y_q <= ray_y[RAY_W-1] ? RAY_W'(-ray_y) : RAY_W'(ray_y);
					st_q    <= ST_DX;
				end
				ST_DX: begin
					if (mag_x_q == '0) begin
						dx_q <= DIST_SAT;
						st_q <= ST_DY;
					end else begin
						st_q <= ST_DXW;
					end
				end
				ST_DXW: begin
					if (div_stat.done) begin
						dx_q <= q_dist;
						st_q <= ST_DY;
					end
				end
				ST_DY: begin
					if (mag_y_q == '0) begin
						dy_q <= DIST_SAT;
						st_q <= ST_SIDE;
					end else begin
						st_q <= ST_DYW;
					end
				end
				ST_DYW: begin
					if (div_stat.done) begin
						dy_q <= q_dist;
						st_q <= ST_SIDE;
					end
				end
				ST_SIDE: begin
					side_x_q <= DIST_W'(sp_x >> F);
					side_y_q <= DIST_W'(sp_y >> F);
					mx_q     <= MPOS_W'(pos_x_q >> F);
					my_q     <= MPOS_W'(pos_y_q >> F);
					it_q     <= '0;
					st_q     <= ST_STEP;
				end
				ST_STEP: begin
					if (side_x_q < side_y_q) begin
						mx_q     <= neg_x_q ? mx_q - MPOS_W'(1) : mx_q + MPOS_W'(1);
						side_x_q <= sum_x[DIST_W] ? DIST_SAT : sum_x[DIST_W-1:0];
						side_q   <= 1'b0;
					end else begin
						my_q     <= neg_y_q ? my_q - MPOS_W'(1) : my_q + MPOS_W'(1);
						side_y_q <= sum_y[DIST_W] ? DIST_SAT : sum_y[DIST_W-1:0];
						side_q   <= 1'b1;
					end
					it_q <= it_q + IT_W'(1);
					st_q <= ST_ADDR;
				end
				ST_ADDR: begin
					if (off_map) begin
						code_q <= '0;
						st_q   <= ST_LINE;
					end else begin
						st_q <= ST_HIT;
					end
				end
				ST_HIT: begin
					code_q <= rd_data;
					if (rd_data != '0 || it_q == IT_W'(ITER_MAX)) begin
						st_q <= ST_LINE;
					end else begin
						st_q <= ST_STEP;
					end
				end
				ST_LINE: begin
					if (perp == '0) begin
						line_q <= LINE_W'(LINE_MAX);
						st_q   <= ST_FIN;
					end else begin
						st_q <= ST_LINEW;
					end
				end
				ST_LINEW: begin
					if (div_stat.done) begin
						line_q <= (div_quo > NUM_W'(LINE_MAX)) ?
							LINE_W'(LINE_MAX) : LINE_W'(div_quo);
						st_q   <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (!m_tvalid || m_tready) begin
						m_tvalid <= 1'b1;
						m_tdata  <= {M_PAD_W'(0), colour, side_q, code_q,
							ROW_W'(dend), ROW_W'(dstart), col_q};
						st_q     <= ST_IDLE;
					end
				end
				default: begin
					st_q <= ST_IDLE;
				end
			endcase
		end
	end

	a_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> !div_stat.busy)
		else $error("divider started while busy");

	a_iter_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(it_q) <= ITER_MAX)
		else $error("dda step count past limit");

	a_result_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(st_q == ST_FIN))
		else $error("result item not from a finished cast");

	a_read_in_map: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_HIT) |-> !off_map)
		else $error("map read outside the map");

endmodule

[dv/tb_grid_raycast_wall_column.sv]
// ----------------------------------------------------------------------------
// tb_grid_raycast_wall_column
// self-checking bench for the grid dda wall column caster
// ----------------------------------------------------------------------------
// A short table of map writes and casts runs first: reset view, extreme
// columns, columns past the screen, the map corners and every wall code.
// Random phases follow. Each phase sets new camera registers while the block
// is idle. The settings include the extremes, integer positions and zero ray
// components. Between settings, random cell writes and casts go in. A local
// model of the map and of the ray walk predicts every stripe. Results are
// compared field by field, in order. Both stream sides idle at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_grid_raycast_wall_column;

	import grc_pkg::*;

	localparam logic [63:0] DIST_LIMIT = 64'hFFFF_FFFF;
	localparam int N_PHASES = 8;
	localparam int PHASE_ITEMS = 190;

	typedef struct packed {
		logic [COL_W-1:0]  column;
		logic [ROW_W-1:0]  row_start;
		logic [ROW_W-1:0]  row_stop;
		logic [CODE_W-1:0] code;
		logic              side;
		logic [RGB_W-1:0]  colour;
	} stripe_t;

	typedef struct {
		logic              mode;
		logic [CELL_W-1:0] cx;
		logic [CELL_W-1:0] cy;
		logic [CODE_W-1:0] code;
		logic [COL_W-1:0]  column;
		bit                typed;
		stripe_t           want;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [S_DATA_W-1:0] s_tdata = '0;
	logic s_tuser = 1'b0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [M_DATA_W-1:0] m_tdata;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0] cfg_data = '0;

	logic [POS_W-1:0] pos_x = POS_X_RST, pos_y = POS_Y_RST;
	logic [DIR_W-1:0] dir_x = DIR_X_RST, dir_y = DIR_Y_RST;
	logic [DIR_W-1:0] plane_x = PLANE_X_RST, plane_y = PLANE_Y_RST;
	logic [CODE_W-1:0] cell_map [0:1023];

	stripe_t stripe_q[$];
	int errors = 0;
	int n_casts = 0, n_writes = 0, n_hits = 0;
	int rx_stall = 0;
	bit idling = 1'b1;
	dir_row_t rows[$];

	always #2 clk = ~clk;

	grid_raycast_wall_column u_top (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	function automatic logic [63:0] step_dist(longint r);
		logic [63:0] m, q;
		m = r < 0 ? -r : r;
		if (m == 0)
			return DIST_LIMIT;
		q = (64'd1 << 32) / m;
		return q > DIST_LIMIT ? DIST_LIMIT : q;
	endfunction

	function automatic logic [63:0] dist_add(logic [63:0] a, logic [63:0] b);
		logic [63:0] s;
		s = a + b;
		return s > DIST_LIMIT ? DIST_LIMIT : s;
	endfunction

	function automatic stripe_t predict_stripe(logic [COL_W-1:0] col);
		longint cam, rx, ry, mx, my, sx, sy, st, en;
		logic [63:0] dx, dy, fx, fy, sdx, sdy, perp, line;
		logic side;
		logic [CODE_W-1:0] code;
		logic [RGB_W-1:0] c;
		bit done;
		stripe_t r;
		cam = ((longint'(col) * 2 - 800) * 65536) / 800;
		rx = longint'($signed(dir_x)) + ((longint'($signed(plane_x)) * cam) >>> 16);
		ry = longint'($signed(dir_y)) + ((longint'($signed(plane_y)) * cam) >>> 16);
		mx = longint'(pos_x[20:16]);
		my = longint'(pos_y[20:16]);
		dx = step_dist(rx);
		dy = step_dist(ry);
		fx = {48'b0, pos_x[15:0]};
		fy = {48'b0, pos_y[15:0]};
		if (rx < 0) begin
			sx = -1;
		end else begin
			sx = 1;
			fx = 64'd65536 - fx;
		end
		if (ry < 0) begin
			sy = -1;
		end else begin
			sy = 1;
			fy = 64'd65536 - fy;
		end
		sdx = (fx * dx) >> 16;
		sdy = (fy * dy) >> 16;
		side = 1'b0;
		code = '0;
		done = 1'b0;
		for (int i = 0; i < 68 && !done; i++) begin
			if (sdx < sdy) begin
				mx += sx;
				sdx = dist_add(sdx, dx);
				side = 1'b0;
			end else begin
				my += sy;
				sdy = dist_add(sdy, dy);
				side = 1'b1;
			end
			if (mx < 0 || mx >= 32 || my < 0 || my >= 32) begin
				code = '0;
				done = 1'b1;
			end else begin
				code = cell_map[mx * 32 + my];
				done = code != 0;
			end
		end
		perp = side ? sdy - dy : sdx - dx;
		if (perp == 0) begin
			line = 64'd1280;
		end else begin
			line = (64'd640 << 16) / perp;
			if (line > 64'd1280)
				line = 64'd1280;
		end
		st = 320 - longint'(line / 2);
		if (st < 0)
			st = 0;
		en = longint'(line / 2) + 320;
		if (en >= 640)
			en = 639;
		case (code)
			CODE_RED:   c = RGB_RED;
			CODE_GREEN: c = RGB_GREEN;
			CODE_BLUE:  c = RGB_BLUE;
			CODE_WHITE: c = RGB_WHITE;
			default:    c = RGB_YELLOW;
		endcase
		if (side)
			c = c >> 1;
		r.column = col;
		r.row_start = st[ROW_W-1:0];
		r.row_stop = en[ROW_W-1:0];
		r.code = code;
		r.side = side;
		r.colour = c;
		return r;
	endfunction

	task automatic report(string what, logic [63:0] got, logic [63:0] want);
		$display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
		errors++;
	endtask

	// result side: random back-pressure and in-order checking
	always @(posedge clk) begin
		stripe_t w;
		if (m_tvalid && m_tready) begin
			if (stripe_q.size() == 0) begin
				report("unexpected result", m_tdata, 64'd0);
			end else begin
				w = stripe_q.pop_front();
				if (m_tdata[9:0] != w.column)
					report("column", 64'(m_tdata[9:0]), 64'(w.column));
				if (m_tdata[19:10] != w.row_start)
					report("draw_start", 64'(m_tdata[19:10]), 64'(w.row_start));
				if (m_tdata[29:20] != w.row_stop)
					report("draw_end", 64'(m_tdata[29:20]), 64'(w.row_stop));
				if (m_tdata[32:30] != w.code)
					report("hit_code", 64'(m_tdata[32:30]), 64'(w.code));
				if (m_tdata[33] != w.side)
					report("hit_side", 64'(m_tdata[33]), 64'(w.side));
				if (m_tdata[57:34] != w.colour)
					report("colour", 64'(m_tdata[57:34]), 64'(w.colour));
				if (w.code != 0)
					n_hits++;
			end
			rx_stall = idling ? $urandom_range(0, 7) : 0;
		end
		if (rx_stall > 0) begin
			m_tready <= 1'b0;
			rx_stall--;
		end else begin
			m_tready <= 1'b1;
		end
	end

	task automatic send_item(logic mode, logic [CELL_W-1:0] cx, logic [CELL_W-1:0] cy,
		logic [CODE_W-1:0] code, logic [COL_W-1:0] col, bit typed, stripe_t want);
		int gap;
		gap = idling ? $urandom_range(0, 7) : 0;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= mode;
		s_tdata <= {1'b0, col, code, cy, cx};
		do @(posedge clk); while (!s_tready);
		if (mode == 1'b0) begin
			cell_map[cx * 32 + cy] = code;
			n_writes++;
		end else begin
			stripe_q.push_back(typed ? want : predict_stripe(col));
			n_casts++;
		end
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (stripe_q.size() != 0) @(posedge clk);
		repeat (12) @(posedge clk);
	endtask

	task automatic write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			REG_POS_X:   pos_x = val[POS_W-1:0];
			REG_POS_Y:   pos_y = val[POS_W-1:0];
			REG_DIR_X:   dir_x = val[DIR_W-1:0];
			REG_DIR_Y:   dir_y = val[DIR_W-1:0];
			REG_PLANE_X: plane_x = val[DIR_W-1:0];
			REG_PLANE_Y: plane_y = val[DIR_W-1:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic push_row(int mode, int cx, int cy, int code, int col);
		dir_row_t r;
		r.mode = 1'(mode);
		r.cx = CELL_W'(cx);
		r.cy = CELL_W'(cy);
		r.code = CODE_W'(code);
		r.column = COL_W'(col);
		r.typed = 1'b0;
		r.want = '0;
		rows.push_back(r);
	endtask

	initial begin
		dir_row_t r;
		logic [POS_W-1:0] px, py;
		logic [DIR_W-1:0] dx, dy, plx, ply;
		for (int i = 0; i < 1024; i++)
			cell_map[i] = '0;

		// straight ahead from the reset view across an empty map
		r.mode = 1'b1;
		r.cx = '0;
		r.cy = '0;
		r.code = '0;
		r.column = 10'd400;
		r.typed = 1'b1;
		r.want = '{10'd400, 10'd306, 10'd334, 3'd0, 1'b0, RGB_YELLOW};
		rows.push_back(r);
		push_row(1, 0, 0, 0, 0);
		push_row(1, 0, 0, 0, 799);
		push_row(1, 0, 0, 0, 1023);
		push_row(0, 0, 0, 7, 0);
		push_row(0, 31, 31, 7, 0);
		push_row(0, 31, 0, 5, 0);
		push_row(0, 0, 31, 6, 0);
		push_row(0, 15, 12, 1, 0);
		push_row(1, 0, 0, 0, 400);
		push_row(0, 15, 12, 2, 0);
		push_row(1, 0, 0, 0, 400);
		push_row(0, 15, 12, 3, 0);
		push_row(1, 0, 0, 0, 399);
		push_row(0, 15, 12, 4, 0);
		push_row(1, 0, 0, 0, 401);
		push_row(0, 21, 8, 7, 0);
		push_row(1, 0, 0, 0, 0);
		push_row(0, 20, 17, 2, 0);
		push_row(1, 0, 0, 0, 799);
		push_row(0, 21, 12, 3, 0);
		push_row(1, 0, 0, 0, 400);
		push_row(1, 0, 0, 0, 1023);
		push_row(0, 21, 12, 0, 0);

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (rows[i])
			send_item(rows[i].mode, rows[i].cx, rows[i].cy, rows[i].code, rows[i].column,
				rows[i].typed, rows[i].want);

		for (int ph = 0; ph < N_PHASES; ph++) begin
			drain();
			idling = ph != 3;
			px = POS_W'($urandom_range(0, 2097151));
			py = POS_W'($urandom_range(0, 2097151));
			dx = DIR_W'($urandom);
			dy = DIR_W'($urandom);
			plx = DIR_W'($urandom);
			ply = DIR_W'($urandom);
			case (ph)
				1: begin
					px = '0;
					py = '1;
					dx = 18'h20000;
					dy = 18'h1FFFF;
					plx = 18'h1FFFF;
					ply = 18'h20000;
				end
				2: begin
					px = '1;
					py = '0;
					dx = 18'h1FFFF;
					dy = 18'h20000;
					plx = 18'h20000;
					ply = 18'h1FFFF;
				end
				4: begin
					px[15:0] = '0;
					py[15:0] = '0;
					dx = '0;
					plx = '0;
				end
				5: begin
					dy = '0;
					ply = '0;
					px[15:0] = '0;
				end
				6: begin
					dx = 18'd1;
					dy = 18'h3FFFF;
					plx = '0;
					ply = '0;
				end
				default: ;
			endcase
			write_reg(REG_POS_X, px);
			write_reg(REG_POS_Y, py);
			write_reg(REG_DIR_X, CFG_W'(dx));
			write_reg(REG_DIR_Y, CFG_W'(dy));
			write_reg(REG_PLANE_X, CFG_W'(plx));
			write_reg(REG_PLANE_Y, CFG_W'(ply));
			for (int k = 0; k < PHASE_ITEMS; k++) begin
				if (ph == 2 && k == PHASE_ITEMS / 2) begin
					s_tvalid <= 1'b0;
					@(posedge clk);
					while (stripe_q.size() != 0) @(posedge clk);
				end
				if ($urandom_range(0, 9) < 4)
					send_item(1'b0, CELL_W'($urandom), CELL_W'($urandom),
						$urandom_range(0, 1) ? 3'd0 : 3'($urandom), '0, 1'b0, '0);
				else
					send_item(1'b1, '0, '0, '0,
						$urandom_range(0, 7) == 0 ? 10'($urandom) : 10'($urandom_range(0, 799)),
						1'b0, '0);
			end
		end

		s_tvalid <= 1'b0;
		@(posedge clk);
		while (stripe_q.size() != 0) @(posedge clk);
		repeat (600) @(posedge clk);
		$display("run: %0d casts (%0d wall hits), %0d cell writes over %0d camera settings",
			n_casts, n_hits, n_writes, N_PHASES);
		$display("settings included extreme registers, integer positions, zero ray components");
		if (errors == 0 && stripe_q.size() == 0) begin
			$display("[grid_raycast_wall_column] OK");
		end else begin
			$display("%0d mismatches, %0d results missing", errors, stripe_q.size());
			$display("[grid_raycast_wall_column] ERROR");
		end
		$finish;
	end

	initial begin
		#20ms;
		$display("timeout with %0d results outstanding", stripe_q.size());
		$display("[grid_raycast_wall_column] ERROR");
		$finish;
	end

endmodule
